/* rtl/enc8b10b_pkg.sv */
// Package with the 8b/10b code tables and packer constants.
package enc8b10b_pkg;

  // 5b/6b codes at negative running disparity, bit a in the MSB.
  localparam logic [5:0] CODE6_NEG [32] = '{
    6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
    6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
    6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
    6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
  };

  // 3b/4b codes at negative running disparity, bit f in the MSB.
  localparam logic [3:0] CODE4_NEG [8] = '{
    4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
  };

  // Alternate D.x.A7 code and the x values that select it.
  localparam logic [3:0] CODE4_ALT7 = 4'h7;
  localparam logic [4:0] ALT_NEG_X0 = 5'd17;
  localparam logic [4:0] ALT_NEG_X1 = 5'd18;
  localparam logic [4:0] ALT_NEG_X2 = 5'd20;
  localparam logic [4:0] ALT_POS_X0 = 5'd11;
  localparam logic [4:0] ALT_POS_X1 = 5'd13;
  localparam logic [4:0] ALT_POS_X2 = 5'd14;

  // Special-case code points of the subblock tables.
  localparam logic [4:0] X_D7 = 5'd7;
  localparam logic [2:0] Y_D3 = 3'd3;
  localparam logic [2:0] Y_D7 = 3'd7;

  // Pad pattern used to fill the final byte of a message.
  localparam logic [7:0] PAD_PATTERN = 8'h55;

endpackage

/* rtl/enc_8b10b_byte_packer.sv */
// 8b/10b data encoder with an MSB-first byte packer.
//
// Usage: one data byte is taken per transfer on the input channel
// (in_valid_i / in_ready_o, data_byte_i, last_byte_i). Each byte becomes a
// 10-bit data symbol that is appended to the bit stream, and every full
// output byte is delivered by a transfer on the output channel
// (out_valid_o / out_ready_i). An input yields one or two output bytes;
// run_last_o marks the last byte caused by an input, and message_end_o the
// final byte of a message. When last_byte_i is set, leftover bits are padded
// out to a byte and the running disparity and packer return to reset.
// Flow: the input register is written by the input transfer, and the result
// register is loaded from it once it is empty or gives up its last byte.
// Throughput: one output byte per cycle while out_ready_i is high and inputs
// keep arriving; an input that yields two bytes holds the result register for
// both, since the output shows one byte of the result register at a time.
// A new input is accepted while results still wait.
// Reset: running disparity is negative, no leftover bits, both stages empty.
// Stall: with out_ready_i low the result register holds its byte, the input
// register fills once, and then in_ready_o drops until the receiver takes data.
module enc_8b10b_byte_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       message_end_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;

  // Encoder and packer state.
  logic       disp_pos_q, disp_pos_d;
  logic [5:0] left_bits_q, left_bits_d;
  logic [2:0] left_cnt_q, left_cnt_d;

  // Result register: up to two bytes per input.
  logic       res_valid_q;
  logic [7:0] res_byte0_q, res_byte1_q;
  logic       res_two_q;
  logic       res_last_q;
  logic       res_idx_q;

  // Encoder signals.
  logic [4:0] sym_x;
  logic [2:0] sym_y;
  logic [5:0] c6_raw, c6;
  logic       unbal6;
  logic       disp6;
  logic       alt7;
  logic [3:0] c4_raw, c4;
  logic       unbal4;
  logic [9:0] symbol;

  // Packer signals.
  logic [2:0]  cnt;
  logic [5:0]  left_mask;
  logic [15:0] acc;
  logic [4:0]  total;
  logic        two_bytes;
  logic [3:0]  rem;
  logic [7:0]  rem_bits;
  logic [7:0]  byte0;
  logic [7:0]  flush_byte;
  logic        has_flush;

  // Handshake signals.
  logic in_xfer;
  logic out_xfer;
  logic res_done;
  logic load;

  // 5b/6b then 3b/4b encoding at the current running disparity.
  always_comb begin
    sym_x  = in_data_q[4:0];
    sym_y  = in_data_q[7:5];
    c6_raw = enc8b10b_pkg::CODE6_NEG[sym_x];
    unbal6 = ($countones(c6_raw) != 3);
    if (disp_pos_q && (unbal6 || (sym_x == enc8b10b_pkg::X_D7))) begin
      c6 = ~c6_raw;
    end else begin
      c6 = c6_raw;
    end
    disp6 = disp_pos_q ^ unbal6;

    alt7 = 1'b0;
    if (sym_y == enc8b10b_pkg::Y_D7) begin
      if (!disp6) begin
        alt7 = (sym_x == enc8b10b_pkg::ALT_NEG_X0) || (sym_x == enc8b10b_pkg::ALT_NEG_X1) ||
               (sym_x == enc8b10b_pkg::ALT_NEG_X2);
      end else begin
        alt7 = (sym_x == enc8b10b_pkg::ALT_POS_X0) || (sym_x == enc8b10b_pkg::ALT_POS_X1) ||
               (sym_x == enc8b10b_pkg::ALT_POS_X2);
      end
    end
    c4_raw = alt7 ? enc8b10b_pkg::CODE4_ALT7 : enc8b10b_pkg::CODE4_NEG[sym_y];
    unbal4 = ($countones(c4_raw) != 2);
    if (disp6 && (unbal4 || ((sym_y == enc8b10b_pkg::Y_D3) && !alt7))) begin
      c4 = ~c4_raw;
    end else begin
      c4 = c4_raw;
    end
    symbol = {c6, c4};
  end

  // Append the symbol to the leftover bits and cut out full bytes.
  always_comb begin
    cnt        = (left_cnt_q > 3'd6) ? 3'd6 : left_cnt_q;
    left_mask  = 6'((7'd1 << cnt) - 7'd1);
    acc        = {left_bits_q & left_mask, symbol};
    total      = 5'(cnt) + 5'd10;
    two_bytes  = total[4];
    byte0      = 8'(acc >> (total - 5'd8));
    rem        = two_bytes ? 4'd0 : 4'(total - 5'd8);
    rem_bits   = 8'(acc & 16'((17'd1 << rem) - 17'd1));
    flush_byte = 8'((rem_bits << (4'd8 - rem)) | (enc8b10b_pkg::PAD_PATTERN >> rem));
    has_flush  = in_last_q && (rem != 4'd0);
  end

  // Handshake and stage movement.
  assign out_xfer   = res_valid_q && out_ready_i;
  assign res_done   = out_xfer && (res_idx_q == res_two_q);
  assign load       = in_valid_q && (!res_valid_q || res_done);
  assign in_ready_o = !in_valid_q || load;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Next encoder and packer state when an item moves to the result register.
  always_comb begin
    disp_pos_d  = disp_pos_q;
    left_bits_d = left_bits_q;
    left_cnt_d  = left_cnt_q;
    if (load) begin
      if (in_last_q) begin
        disp_pos_d  = 1'b0;
        left_bits_d = '0;
        left_cnt_d  = '0;
      end else begin
        disp_pos_d  = disp6 ^ unbal4;
        left_bits_d = rem_bits[5:0];
        left_cnt_d  = rem[2:0];
      end
    end
  end

  // Control state of the input stage and the encoder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      disp_pos_q  <= 1'b0;
      left_bits_q <= '0;
      left_cnt_q  <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      disp_pos_q  <= disp_pos_d;
      left_bits_q <= left_bits_d;
      left_cnt_q  <= left_cnt_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // Result control: valid flag and which of the two bytes is shown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= 1'b0;
      res_two_q   <= 1'b0;
    end else begin
      if (load) begin
        res_valid_q <= 1'b1;
        res_idx_q   <= 1'b0;
        res_two_q   <= two_bytes || has_flush;
      end else if (res_done) begin
        res_valid_q <= 1'b0;
      end else if (out_xfer) begin
        res_idx_q <= 1'b1;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_byte0_q <= byte0;
      res_byte1_q <= two_bytes ? acc[7:0] : flush_byte;
      res_last_q  <= in_last_q;
    end
  end

  // Output channel.
  assign out_valid_o   = res_valid_q;
  assign out_byte_o    = res_idx_q ? res_byte1_q : res_byte0_q;
  assign run_last_o    = (res_idx_q == res_two_q);
  assign message_end_o = run_last_o && res_last_q;

endmodule
